@@ rtl/core/ltdd_pkg.sv @@
// Shared types, character codes and the base-64 digit decode for the lyric time decoder.
package ltdd_pkg;

	localparam int TIME_WIDTH_DEF = 32;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_CARET = 8'h5e;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	localparam int UNIT_W = 24;
	localparam logic [UNIT_W-1:0] UNIT_SUM_MAX = {UNIT_W{1'b1}};
	localparam logic [UNIT_W-1:0] CARET_UNITS  = UNIT_W'(64);
	localparam int PROD_W = 31;
	localparam logic [PROD_W-1:0] UNIT_MS = PROD_W'(100);

	typedef enum logic [2:0] {
		KIND_OFFSET  = 3'd0,
		KIND_LINE    = 3'd1,
		KIND_UNTIMED = 3'd2,
		KIND_BADHDR  = 3'd3,
		KIND_BADCHR  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_OFFSET = 2'd1,
		PH_LINES  = 2'd2,
		PH_DEAD   = 2'd3
	} phase_t;

	// what the accumulate stage does with a decoded request
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_OFFSET = 2'd1,
		OP_LINE   = 2'd2,
		OP_FLAG   = 2'd3
	} op_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} digit_t;

	function automatic digit_t digit_decode(input logic [7:0] c);
		digit_t     d;
		logic [7:0] t;
		d = '{ok: 1'b1, value: 6'd0};
		t = 8'd0;
		if (c >= 8'h41 && c <= 8'h5a) begin
			t = c - 8'h41;
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			t = c - 8'h61 + 8'd26;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30 + 8'd52;
		end else if (c == CH_PLUS) begin
			t = 8'd62;
		end else if (c == CH_SLASH) begin
			t = 8'd63;
		end else begin
			d.ok = 1'b0;
		end
		d.value = t[5:0];
		return d;
	endfunction

endpackage

@@ rtl/core/lyric_time_delta_decoder_unit.sv @@
// Lyric timestamp record decoder: character pipeline, value decode and line time accumulate.
//
//  channel | signals                           | direction
//  --------+-----------------------------------+----------
//  input   | in_valid, in_ready, char_in[7:0]  | in
//  output  | out_valid, out_ready, kind[2:0],  | out
//          | time_ms[31:0]                     |
//
// One character per cycle unless output stalls; results pass s1, s2 and output registers.
// Stages: input register, decode against phase/sign/unit state (units * 100 constant
// multiply), then line time accumulate with saturation into the output register.
// Reset clears phase, partial value and previous line time; there is no clearing pass.
// A stalled output holds the pipeline back stage by stage; empty stages keep accepting.
module lyric_time_delta_decoder_unit
	import ltdd_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         kind,
	output logic signed [31:0] time_ms
);

	localparam int SUM_W = ((TIME_WIDTH > 32) ? TIME_WIDTH : 32) + 1;
	localparam logic signed [SUM_W-1:0] T_MAX =
		{{(SUM_W - TIME_WIDTH + 1){1'b0}}, {(TIME_WIDTH - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] T_MIN = ~T_MAX;

	function automatic logic signed [TIME_WIDTH-1:0] clamp_time(
		input logic signed [SUM_W-1:0] v
	);
		logic signed [SUM_W-1:0] r;
		r = v;
		if (v > T_MAX) begin
			r = T_MAX;
		end else if (v < T_MIN) begin
			r = T_MIN;
		end
		return TIME_WIDTH'(r);
	endfunction

	// pipeline and state registers
	logic                          valid_s1;
	logic [7:0]                    char_s1;
	logic                          valid_s2;
	op_t                           op_s2;
	kind_t                         kind_s2;
	logic signed [TIME_WIDTH-1:0]  ms_s2;
	phase_t                        phase_q;
	logic                          neg_q;
	logic [UNIT_W-1:0]             unit_q;
	logic signed [TIME_WIDTH-1:0]  prev_q;
	logic                          out_valid_q;
	kind_t                         kind_q;
	logic signed [31:0]            time_q;

	// flow control
	logic out_free, s2_drain, s2_adv, s1_adv, s1_fire, s2_fire, out_load;

	assign out_free = !out_valid_q || out_ready;
	assign s2_drain = (op_s2 == OP_CLEAR) || out_free;
	assign s2_adv   = !valid_s2 || s2_drain;
	assign s1_adv   = !valid_s1 || s2_adv;
	assign s1_fire  = valid_s1 && s2_adv;
	assign s2_fire  = valid_s2 && s2_drain;
	assign out_load = s2_fire && (op_s2 != OP_CLEAR);
	assign in_ready = s1_adv;

	// decode stage
	logic                          started, is_nul;
	digit_t                        dig;
	logic [UNIT_W:0]               units_sum;
	logic [UNIT_W-1:0]             units;
	logic [PROD_W-1:0]             prod;
	logic signed [31:0]            ms32;
	logic signed [TIME_WIDTH-1:0]  ms_sat;
	phase_t                        phase_d;
	logic                          neg_d;
	logic [UNIT_W-1:0]             unit_d;
	logic                          ev_valid;
	op_t                           ev_op;
	kind_t                         ev_kind;

	assign started   = neg_q || (unit_q != '0);
	assign is_nul    = (char_s1 == CH_NUL);
	assign dig       = digit_decode(char_s1);
	assign units_sum = {1'b0, unit_q} + (UNIT_W + 1)'(dig.value);
	assign units     = units_sum[UNIT_W] ? UNIT_SUM_MAX : units_sum[UNIT_W-1:0];
	assign prod      = PROD_W'(units) * UNIT_MS;

	always_comb begin
		ms32 = $signed({1'b0, prod});
		if (neg_q) begin
			ms32 = -ms32;
		end
		ms_sat = clamp_time(SUM_W'(ms32));
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		unit_d  = unit_q;
		priority if (is_nul) begin
			phase_d = PH_HEADER;
			neg_d   = 1'b0;
			unit_d  = '0;
		end else if (phase_q == PH_DEAD) begin
			phase_d = PH_DEAD;
		end else if (phase_q == PH_HEADER) begin
			phase_d = (char_s1 == CH_AT) ? PH_OFFSET : PH_DEAD;
		end else if (char_s1 == CH_MINUS && !started) begin
			neg_d = 1'b1;
		end else if (char_s1 == CH_CARET) begin
			unit_d = (unit_q > UNIT_SUM_MAX - CARET_UNITS) ? UNIT_SUM_MAX
			                                               : unit_q + CARET_UNITS;
		end else if (char_s1 == CH_UNDER && !started && phase_q == PH_LINES) begin
			phase_d = phase_q;
		end else begin
			// a digit ends the value; anything else drops it
			neg_d  = 1'b0;
			unit_d = '0;
			if (dig.ok && phase_q == PH_OFFSET) begin
				phase_d = PH_LINES;
			end
		end
	end

	// decoded request for the accumulate stage
	always_comb begin
		ev_valid = 1'b0;
		ev_op    = OP_FLAG;
		ev_kind  = KIND_BADCHR;
		priority if (is_nul) begin
			ev_valid = 1'b1;
			ev_op    = OP_CLEAR;
		end else if (phase_q == PH_DEAD) begin
			ev_valid = 1'b0;
		end else if (phase_q == PH_HEADER) begin
			ev_valid = (char_s1 != CH_AT);
			ev_kind  = KIND_BADHDR;
		end else if ((char_s1 == CH_MINUS && !started) || char_s1 == CH_CARET) begin
			ev_valid = 1'b0;
		end else if (char_s1 == CH_UNDER && !started && phase_q == PH_LINES) begin
			ev_valid = 1'b1;
			ev_kind  = KIND_UNTIMED;
		end else if (!dig.ok) begin
			ev_valid = 1'b1;
			ev_kind  = KIND_BADCHR;
		end else if (phase_q == PH_OFFSET) begin
			ev_valid = 1'b1;
			ev_op    = OP_OFFSET;
			ev_kind  = KIND_OFFSET;
		end else begin
			ev_valid = 1'b1;
			ev_op    = OP_LINE;
			ev_kind  = KIND_LINE;
		end
	end

	// accumulate stage
	logic signed [SUM_W-1:0]       line_sum;
	logic signed [TIME_WIDTH-1:0]  line_time;
	logic signed [SUM_W-1:0]       res_ext;
	logic signed [31:0]            res_time;

	assign line_sum  = SUM_W'(prev_q) + SUM_W'(ms_s2);
	assign line_time = clamp_time(line_sum);

	always_comb begin
		res_ext = '0;
		unique case (op_s2)
			OP_OFFSET: res_ext = SUM_W'(ms_s2);
			OP_LINE:   res_ext = SUM_W'(line_time);
			OP_FLAG:   res_ext = '0;
			OP_CLEAR:  res_ext = '0;
			default:   res_ext = '0;
		endcase
		res_time = res_ext[31:0];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_HEADER;
			neg_q       <= 1'b0;
			unit_q      <= '0;
			prev_q      <= '0;
		end else begin
			if (s1_adv) begin
				valid_s1 <= in_valid;
			end
			if (s1_fire) begin
				valid_s2 <= ev_valid;
				phase_q  <= phase_d;
				neg_q    <= neg_d;
				unit_q   <= unit_d;
			end else if (s2_fire) begin
				valid_s2 <= 1'b0;
			end
			if (s2_fire && op_s2 == OP_CLEAR) begin
				prev_q <= '0;
			end else if (s2_fire && op_s2 == OP_LINE) begin
				prev_q <= line_time;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			char_s1 <= char_in;
		end
		if (s1_fire) begin
			op_s2   <= ev_op;
			kind_s2 <= ev_kind;
			ms_s2   <= ms_sat;
		end
		if (out_load) begin
			kind_q <= kind_s2;
			time_q <= res_time;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign time_ms   = time_q;

`ifndef SYNTHESIS
	a_flag_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_OFFSET && kind != KIND_LINE |-> time_ms == 32'sd0)
		else $error("flag result carries a nonzero time");

	a_dead_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && phase_q == PH_DEAD && char_s1 != CH_NUL |=> !valid_s2)
		else $error("request produced after a bad header");

	a_header_open: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && phase_q == PH_HEADER && char_s1 == CH_AT |=> phase_q == PH_OFFSET)
		else $error("header did not open the offset value");

	a_nul_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && char_s1 == CH_NUL |=> phase_q == PH_HEADER && !neg_q && unit_q == '0)
		else $error("record end did not clear the decode state");
`endif

endmodule
